>>> hdl/scbp_pkg.sv
// Shared constants and types for the stationary context bit predictor.
`default_nettype none
package scbp_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 65536;
  localparam int unsigned PROB_W            = 16;
  localparam int unsigned OUT_W             = 12;
  localparam int unsigned RATE_W            = 4;
  localparam int unsigned BYTE_W            = 8;

  localparam logic [PROB_W-1:0] PROB_HALF  = 16'h8000;
  localparam logic [RATE_W-1:0] RATE_RESET = 4'd2;

  // bypass of the word written in the same cycle the next read was issued
  typedef struct packed {
    logic              hit;
    logic [PROB_W-1:0] prob;
  } fwd_t;

endpackage
`default_nettype wire

>>> hdl/stationary_context_bit_predictor_core.sv
// Top level of the stationary context bit predictor.
`default_nettype none
// Takes one coded bit per word and returns the 12-bit probability of a one
// for the table row selected by the byte-context hash, read before that
// row is updated. Every bit of a byte shares one row, so only
// TABLE_ENTRIES/256 rows are stored. Throughput is one word per clock
// while item_stall is low. An accepted word is registered into the update
// stage while the RAM reads its row; the update logic then feeds the
// output register, loaded when the stage advances. The result is held
// while result_stall is high. Apart from the clearing pass, the input
// stalls only while a word waits in the update stage behind a stalled
// result. A same-row write in the cycle of the next read is bypassed, so
// back-to-back bits on one row see each other's updates. After reset the
// block sweeps every RAM row to the mid probability and holds item_stall
// high meanwhile; step_shift writes are taken at any time.
module stationary_context_bit_predictor_core #(
  parameter int unsigned TABLE_ENTRIES = scbp_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic                          new_context,
  input  wire logic [scbp_pkg::BYTE_W-1:0]   context_byte,
  input  wire logic                          coded_bit,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic      [scbp_pkg::OUT_W-1:0]    probability_one,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [scbp_pkg::RATE_W-1:0]   step_shift
);

  localparam int unsigned ROWS     = TABLE_ENTRIES / 256;
  localparam int unsigned ROW_BITS = $clog2(ROWS);

  logic                          accept;
  logic                          s1_adv;
  logic                          upd_we;
  logic [ROW_BITS-1:0]           row;

  logic                          clearing;
  logic [ROW_BITS-1:0]           clr_row;
  logic [scbp_pkg::RATE_W-1:0]   rate;

  logic                          s1_valid;
  logic [ROW_BITS-1:0]           s1_row;
  logic                          s1_bit;
  scbp_pkg::fwd_t                fwd;

  logic                          ram_we;
  logic [ROW_BITS-1:0]           ram_waddr;
  logic [scbp_pkg::PROB_W-1:0]   ram_wdata;
  logic [scbp_pkg::PROB_W-1:0]   ram_rdata;
  logic [scbp_pkg::PROB_W-1:0]   prob_old;
  logic [scbp_pkg::PROB_W-1:0]   prob_new;

  assign cfg_ready  = 1'b1;
  assign s1_adv     = !result_valid || !result_stall;
  assign item_stall = clearing || (s1_valid && !s1_adv);
  assign accept     = item_valid && !item_stall;
  assign upd_we     = s1_valid && s1_adv;

  assign ram_we    = clearing || upd_we;
  assign ram_waddr = clearing ? clr_row : s1_row;
  assign ram_wdata = clearing ? scbp_pkg::PROB_HALF : prob_new;

  scbp_ctx #(
    .ROW_BITS (ROW_BITS)
  ) u_ctx (
    .clk          (clk),
    .rst          (rst),
    .take         (accept),
    .new_context  (new_context),
    .context_byte (context_byte),
    .row          (row)
  );

  scbp_ram #(
    .WIDTH (scbp_pkg::PROB_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (row),
    .rdata (ram_rdata)
  );

  scbp_upd u_upd (
    .rdata     (ram_rdata),
    .fwd       (fwd),
    .coded_bit (s1_bit),
    .rate      (rate),
    .prob_old  (prob_old),
    .prob_new  (prob_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_row      <= '0;
      rate         <= scbp_pkg::RATE_RESET;
      s1_valid     <= 1'b0;
      fwd.hit      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_row <= clr_row + ROW_BITS'(1);
        if (clr_row == ROW_BITS'(ROWS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        rate <= step_shift;
      end
      if (accept) begin
        s1_valid <= 1'b1;
        // RAM is read-first: a write to the same row this edge is bypassed
        fwd.hit  <= upd_we && (s1_row == row);
        fwd.prob <= prob_new;
      end else if (upd_we) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row <= row;
      s1_bit <= coded_bit;
    end
    if (upd_we) begin
      probability_one <= prob_old[scbp_pkg::PROB_W-1 -: scbp_pkg::OUT_W];
    end
  end

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> item_stall)
    else $error("word accepted during RAM clearing pass");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word did not reach the update stage");

  a_bypass_needs_write: assert property (@(posedge clk) disable iff (rst)
    ($rose(s1_valid) && fwd.hit) |-> $past(upd_we))
    else $error("bypass flagged without a same-cycle write");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid))
    else $error("result appeared without a word in the update stage");

endmodule
`default_nettype wire

>>> hdl/scbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module scbp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/scbp_ctx.sv
// Running context hash and row selection.
`default_nettype none
module scbp_ctx #(
  parameter int unsigned ROW_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              take,
  input  wire logic                              new_context,
  input  wire logic [scbp_pkg::BYTE_W-1:0]       context_byte,
  output logic      [ROW_BITS-1:0]               row
);

  localparam int unsigned EXT_W = ROW_BITS + scbp_pkg::BYTE_W;

  // Only the low ROW_BITS of the hash ever reach the index, and the low
  // bits of hash*257+byte+1 depend only on the low bits of the hash.
  logic [ROW_BITS-1:0] hash;
  logic [EXT_W-1:0]    ext;
  logic [EXT_W-1:0]    fold;

  always_comb begin
    ext  = EXT_W'(hash);
    fold = ext + (ext << scbp_pkg::BYTE_W) + EXT_W'(context_byte) + EXT_W'(1);
    row  = new_context ? fold[ROW_BITS-1:0] : hash;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (take && new_context) begin
      hash <= fold[ROW_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

>>> hdl/scbp_upd.sv
// Probability select (memory or bypass) and rate-scaled update.
`default_nettype none
module scbp_upd (
  input  wire logic [scbp_pkg::PROB_W-1:0] rdata,
  input  wire scbp_pkg::fwd_t              fwd,
  input  wire logic                        coded_bit,
  input  wire logic [scbp_pkg::RATE_W-1:0] rate,
  output logic      [scbp_pkg::PROB_W-1:0] prob_old,
  output logic      [scbp_pkg::PROB_W-1:0] prob_new
);

  always_comb begin
    prob_old = fwd.hit ? fwd.prob : rdata;
    if (coded_bit) begin
      prob_new = prob_old + ((~prob_old) >> rate);
    end else begin
      prob_new = prob_old - (prob_old >> rate);
    end
  end

endmodule
`default_nettype wire
